FILE: rtl/core/pdr_pkg.sv
// Shared types, constants and the multiply micro-program of the dead-reckoning integrator.
package pdr_pkg;

  localparam int WORD_W       = 32;
  localparam int FRAC_BITS    = 16;
  localparam int TS_W         = 24;
  localparam int TS2_W        = 2 * TS_W;
  localparam int OP_W         = WORD_W + 1;
  localparam int PROD_W       = 2 * OP_W;
  localparam int ACC_W        = PROD_W + TS_W - 8;
  localparam int CORDIC_STEPS = 16;
  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 34;
  localparam int ANG_W        = 35;
  localparam int REM_W        = 34;
  localparam int RED_STEPS    = 15;
  localparam int NUM_UOPS     = 14;

  localparam logic [TS_W-1:0] TS_RESET = 24'd167772;

  localparam longint Q30_TWOPI_L = 64'd6746518852;
  localparam int     RED_SH      = 30 - FRAC_BITS;
  localparam longint TWOPI_F_L   = (Q30_TWOPI_L + (64'd1 << (RED_SH - 1))) >> RED_SH;
  localparam longint RED_OFF_L   = (((64'd1 << (WORD_W - 1)) + TWOPI_F_L - 1) / TWOPI_F_L)
                                   * TWOPI_F_L;

  localparam logic [REM_W-1:0]        TWOPI_F    = REM_W'(TWOPI_F_L);
  localparam logic [REM_W-1:0]        RED_OFFSET = REM_W'(RED_OFF_L);
  localparam logic signed [ANG_W-1:0] Q30_PI     = 35'sd3373259426;
  localparam logic signed [ANG_W-1:0] Q30_HALFPI = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0] Q30_TWOPI  = 35'sd6746518852;
  localparam logic signed [XY_W-1:0]  Q30_GAIN   = 34'sd652032874;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [4:0] {
    SRC_VX, SRC_VY, SRC_OM, SRC_T, SRC_P1, SRC_EPS, SRC_AX, SRC_AY, SRC_COS,
    SRC_SIN, SRC_TS, SRC_TS2L, SRC_TS2H, SRC_WX, SRC_WY, SRC_HD, SRC_NH
  } src_e;

  typedef enum logic [1:0] {SH_16, SH_24, SH_30, SH_49} shift_e;
  typedef enum logic [1:0] {CMB_PASS, CMB_ADD, CMB_SUB} comb_e;
  typedef enum logic [2:0] {
    DST_P1, DST_T, DST_NX, DST_NY, DST_NH, DST_NVX, DST_NVY, DST_NOM
  } dst_e;

  typedef struct packed {
    src_e   a;
    src_e   b;
    shift_e sh;
    logic   chain;
    logic   accum;
    logic   hi;
    src_e   x;
    comb_e  comb;
    dst_e   dst;
  } uop_t;

  typedef struct packed {
    logic              load;
    logic              reduce;
    logic              map;
    logic              fold;
    logic              rotate;
    logic              mul;
    logic              acc;
    logic              rnd;
    logic              sat;
    logic              cmb;
    logic              commit;
    logic [ITER_W-1:0] iter;
    uop_t              uop;
  } cmd_t;

  function automatic uop_t pdr_uop(logic [3:0] idx);
    uop_t u;
    u = '{a: SRC_VX, b: SRC_COS, sh: SH_30, chain: 1'b0, accum: 1'b0, hi: 1'b0,
          x: SRC_P1, comb: CMB_PASS, dst: DST_P1};
    unique case (idx)
      4'd0:  u = '{SRC_VX,  SRC_COS,  SH_30, 1'b0, 1'b0, 1'b0, SRC_P1, CMB_PASS, DST_P1};
      4'd1:  u = '{SRC_VY,  SRC_SIN,  SH_30, 1'b0, 1'b0, 1'b0, SRC_P1, CMB_SUB,  DST_T};
      4'd2:  u = '{SRC_T,   SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_WX, CMB_ADD,  DST_NX};
      4'd3:  u = '{SRC_VY,  SRC_COS,  SH_30, 1'b0, 1'b0, 1'b0, SRC_P1, CMB_PASS, DST_P1};
      4'd4:  u = '{SRC_VX,  SRC_SIN,  SH_30, 1'b0, 1'b0, 1'b0, SRC_P1, CMB_ADD,  DST_T};
      4'd5:  u = '{SRC_T,   SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_WY, CMB_ADD,  DST_NY};
      4'd6:  u = '{SRC_OM,  SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_HD, CMB_ADD,  DST_NH};
      4'd7:  u = '{SRC_EPS, SRC_TS2L, SH_49, 1'b1, 1'b0, 1'b0, SRC_NH, CMB_ADD,  DST_NH};
      4'd8:  u = '{SRC_EPS, SRC_TS2H, SH_49, 1'b0, 1'b1, 1'b1, SRC_NH, CMB_ADD,  DST_NH};
      4'd9:  u = '{SRC_OM,  SRC_VY,   SH_16, 1'b0, 1'b0, 1'b0, SRC_AX, CMB_ADD,  DST_T};
      4'd10: u = '{SRC_T,   SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_VX, CMB_ADD,  DST_NVX};
      4'd11: u = '{SRC_OM,  SRC_VX,   SH_16, 1'b0, 1'b0, 1'b0, SRC_AY, CMB_SUB,  DST_T};
      4'd12: u = '{SRC_T,   SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_VY, CMB_ADD,  DST_NVY};
      4'd13: u = '{SRC_EPS, SRC_TS,   SH_24, 1'b0, 1'b0, 1'b0, SRC_OM, CMB_ADD,  DST_NOM};
      default: u = u;
    endcase
    return u;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_q30(logic [ITER_W-1:0] i);
    logic signed [ANG_W-1:0] t;
    unique case (i)
      4'd0: t = 35'sd843314857;
      4'd1: t = 35'sd497837829;
      4'd2: t = 35'sd263043837;
      4'd3: t = 35'sd133525159;
      4'd4: t = 35'sd67021687;
      4'd5: t = 35'sd33543516;
      4'd6: t = 35'sd16775851;
      4'd7: t = 35'sd8388437;
      4'd8: t = 35'sd4194283;
      4'd9: t = 35'sd2097149;
      default: t = 35'sd1 <<< (6'd30 - {2'b00, i});
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/planar_dead_reckoning_integrator_unit.sv
// Top level of the planar dead-reckoning integrator: stream ports, sequencer and datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata: accel_x, accel_y, angular_accel
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata: pos_x .. yaw_rate (six words)
//  cfg       in         cfg_we_i                       cfg_wdata_i: sample_period (Q0.24)
//
// One item runs the restoring remainder for the heading mod 2pi, a mapping and a folding
// step, 16 CORDIC rotations, and 14 passes through the one shared 33x33 multiplier, each
// pass going through multiply, accumulate, round, saturate and combine states (the Ts^2
// term is two chained multiplies sharing one round, saturate and combine). The result
// register is the state itself; a new item is taken while a result is still waiting, and
// the next commit holds until that result has been transferred.
// Reset clears the state to zero and loads sample_period with 167772.
module planar_dead_reckoning_integrator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] accel_x, [63:32] accel_y, [95:64] angular_accel
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] heading, [127:96] vel_x,
  // [159:128] vel_y, [191:160] yaw_rate
  output logic [191:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i
);

  pdr_pkg::cmd_t cmd;
  logic signed [31:0] pos_x, pos_y, heading, vel_x, vel_y, yaw_rate;

  pdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // datapath loads the inputs on the transfer edge and advances the state on commit
  pdr_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accel_x_i       ($signed(s_axis_tdata[31:0])),
    .accel_y_i       ($signed(s_axis_tdata[63:32])),
    .angular_accel_i ($signed(s_axis_tdata[95:64])),
    .pos_x_o         (pos_x),
    .pos_y_o         (pos_y),
    .heading_o       (heading),
    .vel_x_o         (vel_x),
    .vel_y_o         (vel_y),
    .yaw_rate_o      (yaw_rate)
  );

  assign m_axis_tdata = {yaw_rate, vel_y, vel_x, heading, pos_y, pos_x};

endmodule

FILE: rtl/core/pdr_ctrl.sv
// Sequencer: heading reduction, CORDIC iterations and the multiply micro-program.
module pdr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pdr_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_REDUCE = 11'b000_0000_0010,
    S_MAP    = 11'b000_0000_0100,
    S_FOLD   = 11'b000_0000_1000,
    S_CORDIC = 11'b000_0001_0000,
    S_MUL    = 11'b000_0010_0000,
    S_ACC    = 11'b000_0100_0000,
    S_RND    = 11'b000_1000_0000,
    S_SAT    = 11'b001_0000_0000,
    S_CMB    = 11'b010_0000_0000,
    S_COMMIT = 11'b100_0000_0000
  } state_e;

  state_e                     state_q, state_d;
  logic [3:0]                 op_q, op_d;
  logic [pdr_pkg::ITER_W-1:0] iter_q, iter_d;
  logic                       out_valid_q, out_valid_d;
  pdr_pkg::uop_t              uop;

  assign uop         = pdr_pkg::pdr_uop(op_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    iter_d      = '0;
    cmd_o       = '0;
    cmd_o.iter  = iter_q;
    cmd_o.uop   = uop;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd_o.reduce = 1'b1;
        if (iter_q == 4'(pdr_pkg::RED_STEPS - 1)) begin
          state_d = S_MAP;
        end else begin
          iter_d = iter_q + 4'd1;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_FOLD;
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = S_CORDIC;
      end
      S_CORDIC: begin
        cmd_o.rotate = 1'b1;
        if (iter_q == 4'(pdr_pkg::CORDIC_STEPS - 1)) begin
          op_d    = '0;
          state_d = S_MUL;
        end else begin
          iter_d = iter_q + 4'd1;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (uop.chain) begin
          op_d    = op_q + 4'd1;
          state_d = S_MUL;
        end else begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        state_d   = S_CMB;
      end
      S_CMB: begin
        cmd_o.cmb = 1'b1;
        if (op_q == 4'(pdr_pkg::NUM_UOPS - 1)) begin
          state_d = S_COMMIT;
        end else begin
          op_d    = op_q + 4'd1;
          state_d = S_MUL;
        end
      end
      S_COMMIT: begin
        // hold until the previous result has left
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while result still pending");

  a_valid_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_COMMIT))
    else $error("result valid without commit");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_REDUCE && iter_q == '0))
    else $error("accepted transfer did not start reduction");

endmodule

FILE: rtl/core/pdr_datapath.sv
// State registers, angle reduction, CORDIC and the shared multiply-round-saturate unit.
module pdr_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pdr_pkg::cmd_t                   cmd_i,
  input  logic                            cfg_we_i,
  input  logic [pdr_pkg::TS_W-1:0]        cfg_wdata_i,
  input  logic signed [pdr_pkg::WORD_W-1:0] accel_x_i,
  input  logic signed [pdr_pkg::WORD_W-1:0] accel_y_i,
  input  logic signed [pdr_pkg::WORD_W-1:0] angular_accel_i,
  output logic signed [pdr_pkg::WORD_W-1:0] pos_x_o,
  output logic signed [pdr_pkg::WORD_W-1:0] pos_y_o,
  output logic signed [pdr_pkg::WORD_W-1:0] heading_o,
  output logic signed [pdr_pkg::WORD_W-1:0] vel_x_o,
  output logic signed [pdr_pkg::WORD_W-1:0] vel_y_o,
  output logic signed [pdr_pkg::WORD_W-1:0] yaw_rate_o
);

  localparam int W  = pdr_pkg::WORD_W;
  localparam int OW = pdr_pkg::OP_W;
  localparam int AW = pdr_pkg::ACC_W;

  logic [pdr_pkg::TS_W-1:0]  ts_q;
  logic [pdr_pkg::TS2_W-1:0] ts2_q;
  logic signed [W-1:0] ax_q, ay_q, eps_q;
  logic signed [W-1:0] wx_q, wy_q, hd_q, vx_q, vy_q, om_q;
  logic signed [W-1:0] nx_q, ny_q, nh_q, nvx_q, nvy_q, nom_q, p1_q, t_q;
  logic [pdr_pkg::REM_W-1:0]         rem_q;
  logic signed [pdr_pkg::ANG_W-1:0]  ang_q;
  logic                              flip_q;
  logic signed [pdr_pkg::XY_W-1:0]   cx_q, cy_q;
  logic signed [pdr_pkg::PROD_W-1:0] prod_q;
  logic signed [AW-1:0]              acc_q;
  logic [AW-1:0]                     mag_q;
  logic                              neg_q;
  logic signed [W-1:0]               r_q;

  logic signed [pdr_pkg::XY_W-1:0] cos_v, sin_v;

  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;

  function automatic logic signed [OW-1:0] pick(pdr_pkg::src_e s);
    logic signed [OW-1:0] v;
    unique case (s)
      pdr_pkg::SRC_VX:   v = OW'(vx_q);
      pdr_pkg::SRC_VY:   v = OW'(vy_q);
      pdr_pkg::SRC_OM:   v = OW'(om_q);
      pdr_pkg::SRC_T:    v = OW'(t_q);
      pdr_pkg::SRC_P1:   v = OW'(p1_q);
      pdr_pkg::SRC_EPS:  v = OW'(eps_q);
      pdr_pkg::SRC_AX:   v = OW'(ax_q);
      pdr_pkg::SRC_AY:   v = OW'(ay_q);
      pdr_pkg::SRC_COS:  v = cos_v[OW-1:0];
      pdr_pkg::SRC_SIN:  v = sin_v[OW-1:0];
      pdr_pkg::SRC_TS:   v = $signed({9'b0, ts_q});
      pdr_pkg::SRC_TS2L: v = $signed({9'b0, ts2_q[pdr_pkg::TS_W-1:0]});
      pdr_pkg::SRC_TS2H: v = $signed({9'b0, ts2_q[pdr_pkg::TS2_W-1:pdr_pkg::TS_W]});
      pdr_pkg::SRC_WX:   v = OW'(wx_q);
      pdr_pkg::SRC_WY:   v = OW'(wy_q);
      pdr_pkg::SRC_HD:   v = OW'(hd_q);
      pdr_pkg::SRC_NH:   v = OW'(nh_q);
      default:           v = '0;
    endcase
    return v;
  endfunction

  // angle reduction and CORDIC
  logic [pdr_pkg::REM_W-1:0]        red_div;
  logic signed [pdr_pkg::ANG_W-1:0] map_a, cord_t;
  logic signed [pdr_pkg::XY_W-1:0]  dx, dy;

  always_comb begin
    red_div = pdr_pkg::TWOPI_F << (4'(pdr_pkg::RED_STEPS - 1) - cmd_i.iter);
    map_a   = $signed({2'b00, rem_q[18:0], 14'b0});
    if (map_a > pdr_pkg::Q30_PI) begin
      map_a = map_a - pdr_pkg::Q30_TWOPI;
    end
    cord_t = pdr_pkg::atan_q30(cmd_i.iter);
    dx     = cy_q >>> cmd_i.iter;
    dy     = cx_q >>> cmd_i.iter;
  end

  // multiply, accumulate, round, saturate, combine
  logic signed [OW-1:0] opa, opb, xv33, rv33, sum33;
  logic signed [AW-1:0] prod_ext, acc_d;
  logic [AW-1:0]        half, mag_d, shr;
  logic [W-1:0]         lim;
  logic signed [W-1:0]  r_d, cmb_d;

  always_comb begin
    opa      = pick(cmd_i.uop.a);
    opb      = pick(cmd_i.uop.b);
    prod_ext = AW'(prod_q);
    acc_d    = (cmd_i.uop.hi ? (prod_ext <<< pdr_pkg::TS_W) : prod_ext)
             + (cmd_i.uop.accum ? acc_q : '0);
    unique case (cmd_i.uop.sh)
      pdr_pkg::SH_16: half = AW'(1) << 15;
      pdr_pkg::SH_24: half = AW'(1) << 23;
      pdr_pkg::SH_30: half = AW'(1) << 29;
      pdr_pkg::SH_49: half = AW'(1) << 48;
      default:        half = '0;
    endcase
    mag_d = acc_q[AW-1] ? (~acc_q + half + AW'(1)) : (acc_q + half);
    unique case (cmd_i.uop.sh)
      pdr_pkg::SH_16: shr = mag_q >> 16;
      pdr_pkg::SH_24: shr = mag_q >> 24;
      pdr_pkg::SH_30: shr = mag_q >> 30;
      pdr_pkg::SH_49: shr = mag_q >> 49;
      default:        shr = '0;
    endcase
    lim = neg_q ? pdr_pkg::WMIN : pdr_pkg::WMAX;
    if ((|shr[AW-1:W]) || (shr[W-1:0] > lim)) begin
      r_d = neg_q ? pdr_pkg::WMIN : pdr_pkg::WMAX;
    end else begin
      r_d = neg_q ? -$signed(shr[W-1:0]) : $signed(shr[W-1:0]);
    end
    xv33  = pick(cmd_i.uop.x);
    rv33  = {r_q[W-1], r_q};
    sum33 = (cmd_i.uop.comb == pdr_pkg::CMB_SUB) ? (xv33 - rv33) : (xv33 + rv33);
    unique case (cmd_i.uop.comb)
      pdr_pkg::CMB_PASS: cmb_d = r_q;
      pdr_pkg::CMB_ADD, pdr_pkg::CMB_SUB: begin
        if (sum33 > OW'(pdr_pkg::WMAX)) begin
          cmb_d = pdr_pkg::WMAX;
        end else if (sum33 < OW'(pdr_pkg::WMIN)) begin
          cmb_d = pdr_pkg::WMIN;
        end else begin
          cmb_d = sum33[W-1:0];
        end
      end
      default: cmb_d = r_q;
    endcase
  end

  // configuration and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= pdr_pkg::TS_RESET;
      wx_q <= '0;
      wy_q <= '0;
      hd_q <= '0;
      vx_q <= '0;
      vy_q <= '0;
      om_q <= '0;
    end else begin
      if (cfg_we_i) begin
        ts_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        wx_q <= nx_q;
        wy_q <= ny_q;
        hd_q <= nh_q;
        vx_q <= nvx_q;
        vy_q <= nvy_q;
        om_q <= nom_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q  <= accel_x_i;
      ay_q  <= accel_y_i;
      eps_q <= angular_accel_i;
      ts2_q <= ts_q * ts_q;
      rem_q <= pdr_pkg::REM_W'($signed({{2{hd_q[W-1]}}, hd_q})) + pdr_pkg::RED_OFFSET;
    end
    if (cmd_i.reduce && (rem_q >= red_div)) begin
      rem_q <= rem_q - red_div;
    end
    if (cmd_i.map) begin
      ang_q <= map_a;
    end
    if (cmd_i.fold) begin
      cx_q <= pdr_pkg::Q30_GAIN;
      cy_q <= '0;
      if (ang_q > pdr_pkg::Q30_HALFPI) begin
        ang_q  <= ang_q - pdr_pkg::Q30_PI;
        flip_q <= 1'b1;
      end else if (ang_q < -pdr_pkg::Q30_HALFPI) begin
        ang_q  <= ang_q + pdr_pkg::Q30_PI;
        flip_q <= 1'b1;
      end else begin
        flip_q <= 1'b0;
      end
    end
    if (cmd_i.rotate) begin
      if (ang_q >= 0) begin
        cx_q  <= cx_q - dx;
        cy_q  <= cy_q + dy;
        ang_q <= ang_q - cord_t;
      end else begin
        cx_q  <= cx_q + dx;
        cy_q  <= cy_q - dy;
        ang_q <= ang_q + cord_t;
      end
    end
    if (cmd_i.mul) begin
      prod_q <= opa * opb;
    end
    if (cmd_i.acc) begin
      acc_q <= acc_d;
    end
    if (cmd_i.rnd) begin
      mag_q <= mag_d;
      neg_q <= acc_q[AW-1];
    end
    if (cmd_i.sat) begin
      r_q <= r_d;
    end
    if (cmd_i.cmb) begin
      unique case (cmd_i.uop.dst)
        pdr_pkg::DST_P1:  p1_q  <= cmb_d;
        pdr_pkg::DST_T:   t_q   <= cmb_d;
        pdr_pkg::DST_NX:  nx_q  <= cmb_d;
        pdr_pkg::DST_NY:  ny_q  <= cmb_d;
        pdr_pkg::DST_NH:  nh_q  <= cmb_d;
        pdr_pkg::DST_NVX: nvx_q <= cmb_d;
        pdr_pkg::DST_NVY: nvy_q <= cmb_d;
        pdr_pkg::DST_NOM: nom_q <= cmb_d;
        default: p1_q <= cmb_d;
      endcase
    end
  end

  assign pos_x_o    = wx_q;
  assign pos_y_o    = wy_q;
  assign heading_o  = hd_q;
  assign vel_x_o    = vx_q;
  assign vel_y_o    = vy_q;
  assign yaw_rate_o = om_q;

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.map |-> (rem_q < pdr_pkg::TWOPI_F))
    else $error("heading remainder not below two pi");

  a_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.rotate && cmd_i.iter == '0) |->
      (ang_q <= pdr_pkg::Q30_HALFPI && ang_q >= -pdr_pkg::Q30_HALFPI))
    else $error("CORDIC angle outside half pi");

  a_reduce_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.reduce |-> (cmd_i.iter <= 4'(pdr_pkg::RED_STEPS - 1)))
    else $error("reduction step count out of range");

endmodule
